// File: rtl/core/gma_pkg.sv
// shared constants and types for the growing-window moving average
// no dependencies
package gma_pkg;

	localparam int WINDOW_MAX  = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_BITS   = $clog2(WINDOW_MAX);
	localparam int LEN_BITS    = 11;
	localparam int SUM_BITS    = 26;
	localparam int QUOT_BITS   = SAMPLE_BITS;
	localparam int HI_BITS     = SUM_BITS - QUOT_BITS;
	localparam int STEP_BITS   = $clog2(QUOT_BITS);

	localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(64);
	localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(WINDOW_MAX);

	typedef struct packed {
		logic                start;
		logic                neg;
		logic [SUM_BITS-1:0] mag;
		logic [LEN_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUOT_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

// File: rtl/core/growing_moving_average.sv
// top level of the growing-window moving average
// depends on gma_pkg, gma_ram and gma_div
//
// Averages the last window_length Q1.15 samples; during start-up, and after every write of
// window_length, it averages all samples seen so far. The result is the sum divided by the
// number of samples, truncated toward zero. One sample is handled at a time; a request passes
// through the delay-line read, sum update, bit-serial divider and output load. A new request
// is taken while the previous result waits in the output register. A window_length of zero
// acts as one, values above 1024 as 1024. Writing window_length clears the history, sum and
// count; a write is taken only while no sample is in flight, and it wins over a sample request
// offered in the same cycle.
module growing_moving_average import gma_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [SAMPLE_BITS-1:0] m_tdata,   // [15:0] average
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LEN_BITS-1:0]    cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                      state_q;
	logic [LEN_BITS-1:0]         window_q;
	logic [LEN_BITS-1:0]         fill_q;
	logic [ADDR_BITS-1:0]        wp_q;
	logic signed [SUM_BITS-1:0]  sum_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                        fresh_q;
	logic                        m_tvalid_q;
	logic [SAMPLE_BITS-1:0]      m_tdata_q;

	logic [LEN_BITS-1:0]         eff_len;
	logic                        accept;
	logic                        cfg_wr;
	logic [SAMPLE_BITS-1:0]      ram_rdata;
	logic signed [SAMPLE_BITS-1:0] leaving;
	logic signed [SUM_BITS-1:0]  sum_next;
	logic [LEN_BITS-1:0]         wp_inc;
	logic                        out_free;
	div_req_t                    div_req;
	div_rsp_t                    div_rsp;

	always_comb begin
		if (window_q == '0) begin
			eff_len = LEN_BITS'(1);
		end else if (window_q > LEN_MAX) begin
			eff_len = LEN_MAX;
		end else begin
			eff_len = window_q;
		end
	end

	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign out_free  = !m_tvalid_q || m_tready;

	// slot not yet written since clear while the window is still filling
	assign leaving  = fresh_q ? '0 : $signed(ram_rdata);
	assign sum_next = sum_q + SUM_BITS'(x_q) - SUM_BITS'(leaving);
	assign wp_inc   = {1'b0, wp_q} + 1'b1;

	always_comb begin
		div_req.start   = (state_q == ST_SUM);
		div_req.neg     = sum_next[SUM_BITS-1];
		div_req.mag     = sum_next[SUM_BITS-1] ? SUM_BITS'(-sum_next) : SUM_BITS'(sum_next);
		div_req.divisor = fill_q;
	end

	gma_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_hist (
		.clk  (clk),
		.we   (state_q == ST_SUM),
		.waddr(wp_q),
		.wdata(x_q),
		.re   (accept),
		.raddr(wp_q),
		.rdata(ram_rdata)
	);

	gma_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			window_q   <= LEN_RESET;
			fill_q     <= '0;
			wp_q       <= '0;
			sum_q      <= '0;
			fresh_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_wr) begin
				window_q <= cfg_data;
				fill_q   <= '0;
				wp_q     <= '0;
				sum_q    <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !cfg_wr) begin
						fresh_q <= (fill_q < eff_len);
						if (fill_q < eff_len) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					sum_q <= sum_next;
					if (wp_inc >= eff_len) begin
						wp_q <= '0;
					end else begin
						wp_q <= wp_inc[ADDR_BITS-1:0];
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= s_tdata;
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= div_rsp.quotient;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: rtl/core/gma_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module gma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/gma_div.sv
// radix-2 restoring divider, one quotient bit per cycle, signed result
// depends on gma_pkg
module gma_div import gma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [LEN_BITS-1:0]  rem_q;
	logic [QUOT_BITS-1:0] shift_q;
	logic [LEN_BITS-1:0]  div_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 busy_q;
	logic                 neg_q;
	logic                 done_q;
	logic [LEN_BITS:0]    trial;
	logic                 qbit;

	always_comb begin
		trial = {rem_q, shift_q[QUOT_BITS-1]} - {1'b0, div_q};
		qbit  = !trial[LEN_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_BITS'(QUOT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient is known to fit, so the upper dividend bits seed the remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= LEN_BITS'(req.mag[SUM_BITS-1:QUOT_BITS]);
			shift_q <= req.mag[QUOT_BITS-1:0];
			div_q   <= req.divisor;
			neg_q   <= req.neg;
		end else if (busy_q) begin
			rem_q   <= qbit ? trial[LEN_BITS-1:0] : {rem_q[LEN_BITS-2:0], shift_q[QUOT_BITS-1]};
			shift_q <= {shift_q[QUOT_BITS-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (~shift_q + 1'b1) : shift_q;

endmodule

// File: rtl/core/gma_checker.sv
// port-level checks for the growing-window moving average, bound to the top level
// depends on gma_pkg and growing_moving_average
module gma_checker import gma_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [SAMPLE_BITS-1:0] m_tdata,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	// one request in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// a result needs the divider, never appears right after a request
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
		else $error("result too early after request");

	// a new result only shows up at the end of a busy period
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a request in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// register write and request never taken together
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !(s_tvalid && s_tready))
		else $error("register write taken with a request");

endmodule

bind growing_moving_average gma_checker u_gma_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
